### rtl/bdf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdf_pkg: shared definitions for the broadcast duplicate filter
// Table geometry, identifier hash, queue entry and control types.
// ----------------------------------------------------------------------------
package bdf_pkg;

  // Identifier and table geometry. TABLE_DEPTH is a power of two, so the
  // table index is the low part of the hash.
  localparam int ID_W        = 64;
  localparam int ID_BYTES    = 8;
  localparam int HASH_W      = 16;
  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  // Only the leading ID_BYTES bytes of an identifier take part.
  localparam logic [ID_W-1:0] ID_MASK = {ID_W{1'b1}} << (ID_W - 8 * ID_BYTES);

  // Depth of the queue between the front and the back.
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } bdf_state_e;

  // One classified identifier waiting for the table lookup.
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [IDX_W-1:0] idx;
  } bdf_entry_t;

  // Status that the back reports to the front.
  typedef struct packed {
    logic clearing;
    logic pop;
  } bdf_back_stat_t;

  // Byte-serial hash: rotate left by three, then XOR in the next byte,
  // first byte taken from the most significant end.
  function automatic logic [HASH_W-1:0] id_hash(input logic [ID_W-1:0] id);
    logic [HASH_W-1:0] h;
    h = '0;
    for (int i = 0; i < ID_BYTES; i++) begin
      h = {h[HASH_W-4:0], h[HASH_W-1:HASH_W-3]} ^
          {{(HASH_W-8){1'b0}}, id[ID_W-1-8*i -: 8]};
    end
    return h;
  endfunction

endpackage
`default_nettype wire

### rtl/bdf_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdf_if: channel interfaces of the broadcast duplicate filter
// Valid/ready channels for identifier beats in and verdict beats out.
// ----------------------------------------------------------------------------

// Identifier channel.
interface bdf_in_if;
  logic                     valid;
  logic                     ready;
  logic [bdf_pkg::ID_W-1:0] bcast_id;

  modport source (output valid, output bcast_id, input ready);
  modport sink   (input valid, input bcast_id, output ready);
endinterface

// Verdict channel.
interface bdf_out_if;
  logic valid;
  logic ready;
  logic drop;

  modport source (output valid, output drop, input ready);
  modport sink   (input valid, input drop, output ready);
endinterface
`default_nettype wire

### rtl/broadcast_duplicate_filter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// broadcast_duplicate_filter_unit: duplicate suppression for broadcasts
// Hashes each 64-bit broadcast identifier into a direct-mapped table and
// reports whether it matches the stored entry (drop) or is new (keep).
//
//   Channel   Dir  Payload            Meaning
//   bcast_i   in   bcast_id [63:0]    identifier, byte 0 in bits 63..56
//   result_o  out  drop               1 = duplicate, 0 = new (stored)
//
// The back end handles each identifier as a registered table read followed
// by the compare and write-back, and takes no new identifier until that
// write-back is done. A two-entry queue sits between the front end
// and the back end, and the verdict is held in an output register, so a
// stalled result port does not stop intake until the queue fills.
// After reset the table is cleared, one entry per cycle, over all 1024 entries;
// bcast_i.ready stays low during that pass.
// ----------------------------------------------------------------------------
module broadcast_duplicate_filter_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bdf_in_if.sink    bcast_i,
  bdf_out_if.source result_o
);

  bdf_pkg::bdf_entry_t     entry;
  logic                    entry_valid;
  bdf_pkg::bdf_back_stat_t back_stat;

  // Intake, hashing and queue.
  bdf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .bcast_i       (bcast_i),
    .stat_i        (back_stat),
    .entry_o       (entry),
    .entry_valid_o (entry_valid)
  );

  // Table lookup, update and verdict.
  bdf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_i       (entry),
    .entry_valid_i (entry_valid),
    .stat_o        (back_stat),
    .result_o      (result_o)
  );

endmodule
`default_nettype wire

### rtl/bdf_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdf_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module bdf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage array with a registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### rtl/bdf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdf_front: identifier intake and classification
// Masks each identifier, hashes it to a table index and queues the pair.
// ----------------------------------------------------------------------------
module bdf_front (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  bdf_in_if.sink                       bcast_i,
  input  wire bdf_pkg::bdf_back_stat_t stat_i,
  output bdf_pkg::bdf_entry_t          entry_o,
  output logic                         entry_valid_o
);

  bdf_pkg::bdf_entry_t                entries_q [bdf_pkg::Q_DEPTH];
  logic [bdf_pkg::QPTR_W-1:0]         wr_ptr_q, wr_ptr_d;
  logic [bdf_pkg::QPTR_W-1:0]         rd_ptr_q, rd_ptr_d;
  logic [bdf_pkg::QCNT_W-1:0]         cnt_q, cnt_d;
  logic                               push;
  logic                               pop;
  logic [bdf_pkg::ID_W-1:0]           id_masked;
  logic [bdf_pkg::HASH_W-1:0]         hash;
  bdf_pkg::bdf_entry_t                new_entry;

  // Classify the incoming identifier.
  always_comb begin
    id_masked     = bcast_i.bcast_id & bdf_pkg::ID_MASK;
    hash          = bdf_pkg::id_hash(id_masked);
    new_entry.id  = id_masked;
    new_entry.idx = hash[bdf_pkg::IDX_W-1:0];
  end

  // No beat is taken while the table is being cleared or the queue is full.
  assign bcast_i.ready = !stat_i.clearing && (cnt_q != bdf_pkg::QCNT_W'(bdf_pkg::Q_DEPTH));
  assign push          = bcast_i.valid && bcast_i.ready;
  assign pop           = stat_i.pop;

  // Queue pointer and occupancy update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == bdf_pkg::QPTR_W'(bdf_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == bdf_pkg::QPTR_W'(bdf_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= new_entry;
    end
  end

  assign entry_o       = entries_q[rd_ptr_q];
  assign entry_valid_o = (cnt_q != '0);

  // The queue never holds more than its depth.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= bdf_pkg::QCNT_W'(bdf_pkg::Q_DEPTH))
    else $error("bdf_front: queue occupancy overflow");

  // Nothing is popped from an empty queue.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> entry_valid_o)
    else $error("bdf_front: pop from empty queue");

  // No identifier enters while the table clear is running.
  a_no_push_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.clearing |-> !push)
    else $error("bdf_front: beat accepted during table clear");

endmodule
`default_nettype wire

### rtl/bdf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdf_back: table lookup and update
// Clears the identifier table after reset, then reads, compares and
// rewrites one entry per queued identifier and registers the verdict.
// ----------------------------------------------------------------------------
module bdf_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire bdf_pkg::bdf_entry_t  entry_i,
  input  wire logic                 entry_valid_i,
  output bdf_pkg::bdf_back_stat_t   stat_o,
  bdf_out_if.source                 result_o
);

  bdf_pkg::bdf_state_e         state_q, state_d;
  logic [bdf_pkg::IDX_W-1:0]   clr_cnt_q, clr_cnt_d;
  logic [bdf_pkg::ID_W-1:0]    id_q;
  logic [bdf_pkg::IDX_W-1:0]   idx_q;
  logic                        out_valid_q, out_valid_d;
  logic                        drop_q, drop_d;
  logic                        out_free;
  logic                        is_dup;
  logic                        ram_we;
  logic [bdf_pkg::IDX_W-1:0]   ram_waddr;
  logic [bdf_pkg::ID_W-1:0]    ram_wdata;
  logic                        ram_re;
  logic [bdf_pkg::ID_W-1:0]    ram_rdata;
  logic                        pop;
  logic                        finish;

  // Identifier table.
  bdf_ram #(
    .WIDTH (bdf_pkg::ID_W),
    .DEPTH (bdf_pkg::TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (entry_i.idx),
    .rdata_o (ram_rdata)
  );

  assign out_free = !out_valid_q || result_o.ready;
  assign is_dup   = (ram_rdata == id_q);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bdf_pkg::ST_CLEAR: begin
        if (clr_cnt_q == bdf_pkg::IDX_W'(bdf_pkg::TABLE_DEPTH - 1)) begin
          state_d = bdf_pkg::ST_IDLE;
        end
      end
      bdf_pkg::ST_IDLE: begin
        if (entry_valid_i) begin
          state_d = bdf_pkg::ST_LOOKUP;
        end
      end
      bdf_pkg::ST_LOOKUP: begin
        if (out_free) begin
          state_d = bdf_pkg::ST_IDLE;
        end
      end
      default: state_d = bdf_pkg::ST_CLEAR;
    endcase
  end

  // Output and datapath control.
  always_comb begin
    pop       = 1'b0;
    finish    = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = id_q;
    clr_cnt_d = clr_cnt_q;
    unique case (state_q)
      bdf_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
      end
      bdf_pkg::ST_IDLE: begin
        pop    = entry_valid_i;
        ram_re = entry_valid_i;
      end
      bdf_pkg::ST_LOOKUP: begin
        finish = out_free;
        ram_we = out_free && !is_dup;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  // Verdict register: loaded when a lookup completes, freed when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    drop_d      = drop_q;
    if (finish) begin
      out_valid_d = 1'b1;
      drop_d      = is_dup;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bdf_pkg::ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Identifier under lookup and verdict payload.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      id_q  <= entry_i.id;
      idx_q <= entry_i.idx;
    end
    drop_q <= drop_d;
  end

  assign stat_o.clearing = (state_q == bdf_pkg::ST_CLEAR);
  assign stat_o.pop      = pop;
  assign result_o.valid  = out_valid_q;
  assign result_o.drop   = drop_q;

  // A popped identifier is looked up in the following cycle.
  a_pop_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> state_q == bdf_pkg::ST_LOOKUP)
    else $error("bdf_back: pop not followed by lookup");

  // A new identifier is always written back when its verdict is keep.
  a_keep_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finish && !is_dup) |-> ram_we && (ram_wdata == id_q))
    else $error("bdf_back: kept identifier not stored");

  // A verdict is only produced after the clear pass.
  a_no_verdict_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.clearing |-> !finish && !pop)
    else $error("bdf_back: lookup activity during table clear");

endmodule
`default_nettype wire

### tb/tb_broadcast_duplicate_filter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_broadcast_duplicate_filter_unit: self-checking bench for the filter
// Offers identifier beats, from a directed table then at random, and checks
// every verdict beat in order against a directed row's typed verdict or a
// behavioral copy of the hashed duplicate table. Both channels idle at random,
// and the verdict side also holds off for one long stretch as beats still come.
// ----------------------------------------------------------------------------
module tb_broadcast_duplicate_filter_unit;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 8;
  localparam int RAND_ITEMS   = 400;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 20;
  localparam int LIMIT_CYCLES = 200000;
  localparam int RECENT_N     = 16;
  localparam int DIR_N        = 21;

  // Identifier whose hash is zero, so it shares table entry 0 with zero.
  localparam logic [bdf_pkg::ID_W-1:0] ZERO_TWIN = 64'h0000_0000_0000_0840;

  // One directed beat; the verdict is typed in only where it is obvious.
  typedef struct {
    logic [bdf_pkg::ID_W-1:0] id;
    bit                       typed;
    bit                       drop;
  } dir_row_t;

  dir_row_t dir_rows [DIR_N] = '{
    // Zero matches the cleared table, twice.
    '{64'h0000_0000_0000_0000, 1'b1, 1'b1},
    '{64'h0000_0000_0000_0000, 1'b1, 1'b1},
    // All ones is new, then a repeat.
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1},
    // A colliding identifier evicts zero, zero evicts it back.
    '{ZERO_TWIN,               1'b1, 1'b0},
    '{64'h0000_0000_0000_0000, 1'b1, 1'b0},
    '{64'h0000_0000_0000_0000, 1'b1, 1'b1},
    '{ZERO_TWIN,               1'b1, 1'b0},
    '{64'h8000_0000_0000_0000, 1'b0, 1'b0},
    '{64'h0000_0000_0000_0001, 1'b0, 1'b0},
    '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0},
    '{64'h5555_5555_5555_5555, 1'b0, 1'b0},
    '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0},
    '{64'h0123_4567_89AB_CDEF, 1'b0, 1'b0},
    '{64'hFEDC_BA98_7654_3210, 1'b0, 1'b0},
    '{64'h0123_4567_89AB_CDEF, 1'b0, 1'b0},
    '{64'h0000_0000_0000_00FF, 1'b0, 1'b0},
    '{64'hFF00_0000_0000_0000, 1'b0, 1'b0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0},
    // Same hash as 0123_4567_89AB_CDEF, so the repeat of that one is missed.
    '{64'h0123_4567_89AB_CCE7, 1'b0, 1'b0},
    '{64'h0123_4567_89AB_CDEF, 1'b0, 1'b0}
  };

  logic clk_i;
  logic rst_ni;

  bdf_in_if  bcast_if ();
  bdf_out_if verdict_if ();

  broadcast_duplicate_filter_unit uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .bcast_i  (bcast_if),
    .result_o (verdict_if)
  );

  // Behavioral copy of the duplicate table and the verdicts still owed.
  logic [bdf_pkg::ID_W-1:0] seen_ids [bdf_pkg::TABLE_DEPTH];
  bit                       drop_q [$];
  int                       fail_cnt;

  // Knobs shared by the stimulus and the verdict side.
  bit tx_idle_en;
  bit rx_idle_en;
  int hold_reqs;
  int hold_seen;
  int hold_left;

  // Recently offered identifiers, reused to make repeats and collisions.
  logic [bdf_pkg::ID_W-1:0] recent_ids [RECENT_N];
  int                       recent_cnt;
  int                       recent_wr;

  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Rotate-and-XOR digest over the leading identifier bytes.
  function automatic logic [bdf_pkg::HASH_W-1:0] id_digest(
    input logic [bdf_pkg::ID_W-1:0] id);
    logic [bdf_pkg::HASH_W-1:0] acc;
    acc = '0;
    for (int b = 0; b < bdf_pkg::ID_BYTES; b++) begin
      acc = (acc << 3) | (acc >> (bdf_pkg::HASH_W - 3));
      acc = acc ^ bdf_pkg::HASH_W'(id[bdf_pkg::ID_W-1-8*b -: 8]);
    end
    return acc;
  endfunction

  // Looks the identifier up, stores it when new, and returns the verdict.
  function automatic bit lookup_verdict(input logic [bdf_pkg::ID_W-1:0] raw_id);
    logic [bdf_pkg::ID_W-1:0] id;
    int                       slot;
    id   = raw_id & bdf_pkg::ID_MASK;
    slot = int'(id_digest(id)) % bdf_pkg::TABLE_DEPTH;
    if (seen_ids[slot] != id) begin
      seen_ids[slot] = id;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Offers one identifier beat and records its verdict once accepted.
  task automatic offer_id(input logic [bdf_pkg::ID_W-1:0] id, input bit typed,
                          input bit typed_drop);
    bit model_drop;
    while (tx_idle_en && ($urandom_range(99) < 25)) begin
      bcast_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    bcast_if.valid    <= 1'b1;
    bcast_if.bcast_id <= id;
    do @(posedge clk_i); while (!bcast_if.ready);
    model_drop = lookup_verdict(id);
    drop_q.push_back(typed ? typed_drop : model_drop);
    recent_ids[recent_wr] = id;
    recent_wr = (recent_wr + 1) % RECENT_N;
    if (recent_cnt < RECENT_N) recent_cnt++;
  endtask

  // Picks a random identifier: repeats, hash twins, extremes or fresh ones.
  function automatic logic [bdf_pkg::ID_W-1:0] pick_id();
    int                       pick;
    logic [4:0]               d;
    logic [bdf_pkg::ID_W-1:0] base;
    pick = $urandom_range(99);
    base = recent_ids[$urandom_range(recent_cnt - 1)];
    d    = 5'($urandom_range(31, 1));
    if (pick < 40) begin
      return base;
    end else if (pick < 55) begin
      // Byte 6 moves by d and byte 7 by d << 3, so the hash is unchanged.
      return base ^ {48'h0, 3'b000, d, d, 3'b000};
    end else if (pick < 60) begin
      case ($urandom_range(2))
        0:       return '0;
        1:       return '1;
        default: return ZERO_TWIN;
      endcase
    end
    return {$urandom, $urandom};
  endfunction

  // Verdict side: check each accepted beat, then decide ready.
  always @(posedge clk_i) begin : verdict_side
    bit want;
    if (verdict_if.valid && verdict_if.ready) begin
      if (drop_q.size() == 0) begin
        $error("unexpected verdict beat: drop=%0b", verdict_if.drop);
        fail_cnt++;
      end else begin
        want = drop_q.pop_front();
        if (verdict_if.drop !== want) begin
          $error("drop mismatch: expected %0b, actual %0b", want, verdict_if.drop);
          fail_cnt++;
        end
      end
    end
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      verdict_if.ready <= 1'b0;
    end else if (rx_idle_en) begin
      verdict_if.ready <= ($urandom_range(99) >= 25);
    end else begin
      verdict_if.ready <= 1'b1;
    end
  end

  // Run limit.
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("FAIL broadcast_duplicate_filter_unit");
    $finish;
  end

  // Main sequence.
  initial begin
    rst_ni              = 1'b0;
    bcast_if.valid      = 1'b0;
    bcast_if.bcast_id   = '0;
    verdict_if.ready    = 1'b0;
    fail_cnt            = 0;
    tx_idle_en          = 1'b1;
    rx_idle_en          = 1'b1;
    hold_reqs           = 0;
    hold_seen           = 0;
    hold_left           = 0;
    recent_cnt          = 0;
    recent_wr           = 0;
    for (int i = 0; i < bdf_pkg::TABLE_DEPTH; i++) seen_ids[i] = '0;
    for (int i = 0; i < RECENT_N; i++) recent_ids[i] = '0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed beats; the clearing pass after reset holds them off.
    for (int r = 0; r < DIR_N; r++) begin
      offer_id(dir_rows[r].id, dir_rows[r].typed, dir_rows[r].drop);
    end

    // Random beats.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == 100) begin
        // Long stall on the verdict side while beats keep coming.
        hold_reqs++;
      end
      if (n == 150) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      if (n == 250) begin
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
      end
      if (n == 300) begin
        // Pause until every verdict has come back.
        bcast_if.valid <= 1'b0;
        @(posedge clk_i);
        while (drop_q.size() != 0) @(posedge clk_i);
      end
      offer_id(pick_id(), 1'b0, 1'b0);
    end
    bcast_if.valid <= 1'b0;

    // Drain the verdicts still owed, then allow for late extra beats.
    while (drop_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("PASS broadcast_duplicate_filter_unit");
    end else begin
      $display("FAIL broadcast_duplicate_filter_unit");
    end
    $finish;
  end

endmodule
`default_nettype wire
